>>> hdl/signed_int_to_decimal_ascii_unit_defines.svh
// assertion macros used by the checks in sidau_controller
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTH

// condition that must hold at every clock edge out of reset
`define SIDAU_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sidau check failed");

// implication checked in the cycle after the antecedent
`define SIDAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidau sequence check failed");

`else

`define SIDAU_ASSERT(lbl, cond)
`define SIDAU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/sidau_pkg.sv
package sidau_pkg;

    // default operand width
    localparam int DEFAULT_VALUE_BITS = 32;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic dec_index;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } sidau_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic conv_done;
        logic digit_zero;
        logic index_zero;
        logic negative;
    } sidau_status_t;

endpackage

>>> hdl/sidau_in_if.sv
interface sidau_in_if
    import sidau_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/sidau_out_if.sv
interface sidau_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hdl/sidau_datapath.sv
module sidau_datapath
    import sidau_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  sidau_cmd_t            cmd,
    output sidau_status_t         status,
    output logic [7:0]            character,
    output logic                  last
);

    // enough decimal digits for 2^VALUE_BITS (1233/4096 a shade under log10 2)
    localparam int DigitCount = ((VALUE_BITS * 1233) / 4096) + 1;
    localparam int BcdBits    = DigitCount * 4;
    localparam int IndexBits  = (DigitCount > 1) ? $clog2(DigitCount) : 1;
    localparam int CountBits  = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BcdBits-1:0]    bcd_reg, bcd_next, bcd_adj;
    logic                  neg_reg, neg_next;
    logic [CountBits-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [IndexBits-1:0]  idx_reg, idx_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digit;

    // unsigned magnitude, exact for the most negative value
    assign magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    // add three to every bcd digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DigitCount; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign digit = bcd_reg[idx_reg*4 +: 4];

    // next-value logic
    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (cmd.load)
        begin
            mag_next     = magnitude;
            bcd_next     = '0;
            neg_next     = value[VALUE_BITS-1];
            bit_cnt_next = '0;
            idx_next     = IndexBits'(DigitCount - 1);
        end
        if (cmd.shift)
        begin
            bcd_next     = {bcd_adj[BcdBits-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.dec_index)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            char_next = CHAR_ZERO + {4'b0000, digit};
            last_next = cmd.last;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            idx_reg     <= idx_next;
            neg_reg     <= neg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.conv_done  = (bit_cnt_reg == CountBits'(VALUE_BITS));
    assign status.digit_zero = (digit == 4'd0);
    assign status.index_zero = (idx_reg == '0);
    assign status.negative   = neg_reg;
    assign character         = char_reg;
    assign last              = last_reg;

endmodule

>>> hdl/sidau_controller.sv
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sidau_controller
    import sidau_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  sidau_status_t status,
    output sidau_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // output register can take a character this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.conv_done)
                begin
                    state_next = ST_SKIP;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_SKIP:
            begin
                if (status.digit_zero && !status.index_zero)
                begin
                    cmd.dec_index = 1'b1;
                end
                else if (status.negative)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    cmd.emit_sign  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    cmd.last       = status.index_zero;
                    out_valid_next = 1'b1;
                    if (status.index_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.dec_index = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // checks
    `SIDAU_ASSERT(a_emit_exclusive, !(cmd.emit_sign && cmd.emit_digit))
    `SIDAU_ASSERT(a_emit_into_free_slot, !(cmd.emit_sign || cmd.emit_digit) || slot_free)
    `SIDAU_ASSERT_NEXT(a_accept_starts_convert, in_valid && in_ready, state_reg == ST_CONVERT)
    `SIDAU_ASSERT_NEXT(a_sign_then_digit, cmd.emit_sign, state_reg == ST_DIGIT && out_valid)

endmodule

>>> hdl/signed_int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII text.
// in_ch (sink) takes one VALUE_BITS two's complement value per transfer.
// out_ch (source) gives one ASCII character per transfer: '-' first for a
// negative value, then the digits most significant first, no leading zeros,
// with last set on the final character of the run. Zero gives '0'.
// One value is in flight at a time; in_ch.ready is high only when idle.
// Per value: an accept, VALUE_BITS steps of shift-and-add-3 conversion in
// the datapath and a step to see it finish, a step per leading zero digit
// skipped (up to 9 at 32 bits), a step to leave the skip, then one
// character per cycle while out_ch.ready stays high. At 32 bits skipped
// digits plus digits always make ten.
// The characters leave through a single output register; when the receiver
// stalls, the character is held and the sequencer waits for the slot.
// Reset clears the sequencer and output valid; no character is pending.
module signed_int_to_decimal_ascii_unit
    import sidau_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    sidau_in_if.sink     in_ch,
    sidau_out_if.source  out_ch
);

    sidau_cmd_t    cmd;
    sidau_status_t status;

    // sequencer
    sidau_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // conversion and output registers
    sidau_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (in_ch.value),
        .cmd       (cmd),
        .status    (status),
        .character (out_ch.character),
        .last      (out_ch.last)
    );

endmodule
